/* src/pfr_pkg.sv */
// shared constants, types and helpers for the pcm frame ring h-bridge drive
// no dependencies
package pfr_pkg;

  localparam int FRAMES      = 4;
  localparam int FRAME_BYTES = 32;
  localparam int PAIRS       = (FRAME_BYTES + 1) / 2;
  localparam int DEPTH       = FRAMES * PAIRS;
  localparam int FRAME_W     = $clog2(FRAMES);
  localparam int OFF_W       = $clog2(FRAME_BYTES);
  localparam int PAIR_W      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam bit ODD_FRAME   = (FRAME_BYTES % 2) == 1;

  localparam logic [7:0] MID_LEVEL = 8'h80;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_DATA    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  localparam logic [1:0] KIND_HOLD  = 2'd0;
  localparam logic [1:0] KIND_PLAY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic       fwd;
    logic       rev;
    logic [6:0] duty;
  } bridge_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       underrun;
    logic       overflow;
    logic       b_pad;
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
  } q_item_t;

  function automatic bridge_t to_bridge(input logic [7:0] v);
    bridge_t b;
    b.fwd  = v[7];
    b.rev  = ~v[7];
    b.duty = v[7] ? v[6:0] : ~v[6:0];
    return b;
  endfunction

endpackage

/* src/pfr_in_if.sv */
// request channel carrying mode and data byte
// depends on nothing
interface pfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

/* src/pfr_out_if.sv */
// result channel carrying bridge pins, duties and flags
// depends on nothing
interface pfr_out_if;
  logic       valid;
  logic       ready;
  logic       a_forward;
  logic       a_reverse;
  logic       b_forward;
  logic       b_reverse;
  logic [6:0] duty_a;
  logic [6:0] duty_b;
  logic       underrun;
  logic       overflow;

  modport source (output valid, output a_forward, output a_reverse, output b_forward,
                  output b_reverse, output duty_a, output duty_b, output underrun,
                  output overflow, input ready);
  modport sink (input valid, input a_forward, input a_reverse, input b_forward,
                input b_reverse, input duty_a, input duty_b, input underrun,
                input overflow, output ready);
endinterface

/* src/pfr_ram.sv */
// generic single write port ram with registered read
// no dependencies
module pfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/pfr_front.sv */
// front end: accepts requests, keeps ring pointers, writes and reads the frame store
// depends on pfr_pkg, pfr_in_if, pfr_ram
module pfr_front
  import pfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  pfr_in_if.sink    in,
  output q_item_t   push_item,
  output logic      push,
  input  logic      full
);

  logic [FRAME_W-1:0] read_frame, read_frame_next;
  logic [PAIR_W-1:0]  read_pair, read_pair_next;
  logic [FRAME_W-1:0] write_frame, write_frame_next;
  logic [OFF_W-1:0]   write_offset, write_offset_next;
  logic [FRAME_W-1:0] frame_inc;

  logic               s1_valid;
  op_t                s1_op, op_next;

  logic               take;
  logic               we_even, we_odd, re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [7:0]         rdata_even, rdata_odd;

  assign push     = s1_valid && !full;
  assign in.ready = !s1_valid || !full;
  assign take     = in.valid && in.ready;

  assign waddr = ADDR_W'(ADDR_W'(write_frame) * ADDR_W'(PAIRS) + ADDR_W'(write_offset >> 1));
  assign raddr = ADDR_W'(ADDR_W'(read_frame) * ADDR_W'(PAIRS) + ADDR_W'(read_pair));

  assign we_even = take && (in.mode == MODE_DATA) && !write_offset[0];
  assign we_odd  = take && (in.mode == MODE_DATA) && write_offset[0];
  assign re      = take && (in.mode == MODE_TICK) && (read_frame != write_frame);

  assign frame_inc = (write_frame == FRAME_W'(FRAMES - 1)) ? '0 : write_frame + 1'b1;

  always_comb begin
    read_frame_next   = read_frame;
    read_pair_next    = read_pair;
    write_frame_next  = write_frame;
    write_offset_next = write_offset;
    op_next           = '{kind: KIND_HOLD, underrun: 1'b0, overflow: 1'b0, b_pad: 1'b0};
    case (in.mode)
      MODE_TICK: begin
        if (read_frame == write_frame) begin
          op_next.underrun = 1'b1;
        end else begin
          op_next.kind = KIND_PLAY;
          if (read_pair == PAIR_W'(PAIRS - 1)) begin
            op_next.b_pad  = ODD_FRAME;
            read_pair_next = '0;
            read_frame_next = (read_frame == FRAME_W'(FRAMES - 1)) ? '0 : read_frame + 1'b1;
          end else begin
            read_pair_next = read_pair + 1'b1;
          end
        end
      end
      MODE_DATA: begin
        if (write_offset == OFF_W'(FRAME_BYTES - 1)) begin
          write_offset_next = '0;
          if (frame_inc == read_frame) begin
            op_next.overflow = 1'b1;
          end else begin
            write_frame_next = frame_inc;
          end
        end else begin
          write_offset_next = write_offset + 1'b1;
        end
      end
      MODE_RESTART: begin
        op_next.kind      = KIND_CLEAR;
        read_frame_next   = '0;
        read_pair_next    = '0;
        write_frame_next  = '0;
        write_offset_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_frame   <= '0;
      read_pair    <= '0;
      write_frame  <= '0;
      write_offset <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (take) begin
        read_frame   <= read_frame_next;
        read_pair    <= read_pair_next;
        write_frame  <= write_frame_next;
        write_offset <= write_offset_next;
        s1_op        <= op_next;
        s1_valid     <= 1'b1;
      end else if (push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // even offsets carry motor a, odd offsets motor b
  pfr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (waddr),
    .wdata (in.data_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_even)
  );

  pfr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (waddr),
    .wdata (in.data_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_odd)
  );

  assign push_item = '{op: s1_op, byte_a: rdata_even, byte_b: rdata_odd};

endmodule

/* src/pfr_fifo.sv */
// two entry queue between front and back
// depends on pfr_pkg
module pfr_fifo
  import pfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output q_item_t pop_item,
  output logic    not_empty
);

  q_item_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/pfr_back.sv */
// back end: updates the held bridge drive and registers the result
// depends on pfr_pkg, pfr_out_if
module pfr_back
  import pfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  q_item_t  pop_item,
  input  logic     not_empty,
  output logic     pop,
  pfr_out_if.source out
);

  bridge_t held_a, held_a_next;
  bridge_t held_b, held_b_next;
  logic    out_valid;

  assign pop       = not_empty && (!out_valid || out.ready);
  assign out.valid = out_valid;

  always_comb begin
    held_a_next = held_a;
    held_b_next = held_b;
    case (pop_item.op.kind)
      KIND_PLAY: begin
        held_a_next = to_bridge(pop_item.byte_a);
        held_b_next = to_bridge(pop_item.op.b_pad ? MID_LEVEL : pop_item.byte_b);
      end
      KIND_CLEAR: begin
        held_a_next = '0;
        held_b_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_a    <= '0;
      held_b    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        held_a    <= held_a_next;
        held_b    <= held_b_next;
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out.a_forward <= held_a_next.fwd;
      out.a_reverse <= held_a_next.rev;
      out.duty_a    <= held_a_next.duty;
      out.b_forward <= held_b_next.fwd;
      out.b_reverse <= held_b_next.rev;
      out.duty_b    <= held_b_next.duty;
      out.underrun  <= pop_item.op.underrun;
      out.overflow  <= pop_item.op.overflow;
    end
  end

endmodule

/* src/pcm_frame_ring_hbridge_drive.sv */
// top level of the two-channel pcm frame ring h-bridge drive
// depends on pfr_pkg, pfr_in_if, pfr_out_if, pfr_front, pfr_fifo, pfr_back
//
//   port  dir  payload
//   in    in   mode[1:0], data_byte[7:0]
//   out   out  a_forward, a_reverse, b_forward, b_reverse, duty_a, duty_b,
//              underrun, overflow
//
// one request per cycle while in.ready is high, one result per request
// each result passes the registered frame store read, the queue and the output register
// rst is synchronous; pointers and held drive clear, frame store contents are undefined
// a stalled out fills the two entry queue, then in.ready drops
module pcm_frame_ring_hbridge_drive
  import pfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  pfr_in_if.sink    in,
  pfr_out_if.source out
);

  q_item_t push_item, pop_item;
  logic    push, full, pop, not_empty;

  pfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in        (in),
    .push_item (push_item),
    .push      (push),
    .full      (full)
  );

  pfr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  pfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_item  (pop_item),
    .not_empty (not_empty),
    .pop       (pop),
    .out       (out)
  );

endmodule

/* tb/sv/pfr_drive_checker.sv */
`timescale 1ns / 100ps
// checker for the pcm frame ring h-bridge drive: predicts each result and compares it
// depends on pfr_pkg, pfr_in_if and pfr_out_if
module pfr_drive_checker
  import pfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pfr_in_if    in_mon,
  pfr_out_if   out_mon,
  output int   errors,
  output int   pending,
  output int   played,
  output int   underruns,
  output int   overflows
);

  typedef struct packed {
    logic       a_fwd;
    logic       a_rev;
    logic       b_fwd;
    logic       b_rev;
    logic [6:0] duty_a;
    logic [6:0] duty_b;
    logic       underrun;
    logic       overflow;
  } drive_sample_t;

  logic [7:0]         ring_bytes [FRAMES*FRAME_BYTES];
  logic [FRAME_W-1:0] rd_frame;
  logic [FRAME_W-1:0] wr_frame;
  logic [OFF_W-1:0]   rd_off;
  logic [OFF_W-1:0]   wr_off;
  bridge_t            held_a;
  bridge_t            held_b;
  drive_sample_t      drive_q [$];

  function automatic bridge_t sample_drive(input logic [7:0] v);
    bridge_t b;
    if (v >= MID_LEVEL) begin
      b.fwd  = 1'b1;
      b.rev  = 1'b0;
      b.duty = 7'(int'(v) - int'(MID_LEVEL));
    end else begin
      b.fwd  = 1'b0;
      b.rev  = 1'b1;
      b.duty = 7'(127 - int'(v));
    end
    return b;
  endfunction

  task automatic predict_drive(input logic [1:0] mode, input logic [7:0] data,
                               output drive_sample_t s);
    int         nxt_off;
    int         nxt_frame;
    int         base;
    logic [7:0] va;
    logic [7:0] vb;
    s = '0;
    case (mode)
      MODE_TICK: begin
        if (rd_frame == wr_frame) begin
          s.underrun = 1'b1;
          underruns++;
        end else begin
          base = int'(rd_frame) * FRAME_BYTES;
          va = ring_bytes[base + int'(rd_off)];
          // odd frame: the b byte past the frame end reads as the zero level
          vb = (int'(rd_off) + 1 < FRAME_BYTES) ? ring_bytes[base + int'(rd_off) + 1]
                                                : MID_LEVEL;
          nxt_off = int'(rd_off) + 2;
          if (nxt_off >= FRAME_BYTES) begin
            rd_off   = '0;
            rd_frame = FRAME_W'((int'(rd_frame) + 1) % FRAMES);
          end else begin
            rd_off = OFF_W'(nxt_off);
          end
          held_a = sample_drive(va);
          held_b = sample_drive(vb);
          played++;
        end
      end
      MODE_DATA: begin
        ring_bytes[int'(wr_frame) * FRAME_BYTES + int'(wr_off)] = data;
        nxt_off = int'(wr_off) + 1;
        if (nxt_off >= FRAME_BYTES) begin
          wr_off    = '0;
          nxt_frame = (int'(wr_frame) + 1) % FRAMES;
          // full ring: drop the frame rather than make the ring look empty
          if (nxt_frame == int'(rd_frame)) begin
            s.overflow = 1'b1;
            overflows++;
          end else begin
            wr_frame = FRAME_W'(nxt_frame);
          end
        end else begin
          wr_off = OFF_W'(nxt_off);
        end
      end
      MODE_RESTART: begin
        rd_frame = '0;
        rd_off   = '0;
        wr_frame = '0;
        wr_off   = '0;
        held_a   = '0;
        held_b   = '0;
      end
      default: ;
    endcase
    s.a_fwd  = held_a.fwd;
    s.a_rev  = held_a.rev;
    s.b_fwd  = held_b.fwd;
    s.b_rev  = held_b.rev;
    s.duty_a = held_a.duty;
    s.duty_b = held_b.duty;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    drive_sample_t want;
    drive_sample_t next;
    if (rst) begin
      rd_frame = '0;
      rd_off   = '0;
      wr_frame = '0;
      wr_off   = '0;
      held_a   = '0;
      held_b   = '0;
      drive_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (drive_q.size() == 0) begin
          $error("result arrived with no request waiting");
          errors++;
        end else begin
          want = drive_q.pop_front();
          check_field("a_forward", want.a_fwd, out_mon.a_forward);
          check_field("a_reverse", want.a_rev, out_mon.a_reverse);
          check_field("b_forward", want.b_fwd, out_mon.b_forward);
          check_field("b_reverse", want.b_rev, out_mon.b_reverse);
          check_field("duty_a", want.duty_a, out_mon.duty_a);
          check_field("duty_b", want.duty_b, out_mon.duty_b);
          check_field("underrun", want.underrun, out_mon.underrun);
          check_field("overflow", want.overflow, out_mon.overflow);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_drive(in_mon.mode, in_mon.data_byte, next);
        drive_q.push_back(next);
      end
    end
    pending = drive_q.size();
  end

endmodule

/* tb/sv/pcm_frame_ring_hbridge_drive_tb.sv */
`timescale 1ns / 100ps
// testbench top for the pcm frame ring h-bridge drive: request stimulus, sink stalls, verdict
// depends on pfr_pkg, pfr_in_if, pfr_out_if, pfr_drive_checker and the block itself
module pcm_frame_ring_hbridge_drive_tb
  import pfr_pkg::*;
();

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         RANDOM_ITEMS   = 1200;
  localparam int         DRAIN_CYCLES   = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pfr_in_if  in_ch ();
  pfr_out_if out_ch ();

  int errors;
  int pending;
  int played;
  int underruns;
  int overflows;
  int sent;
  int ignored;
  int restarts;
  int idle_cycles;
  int stall_left;
  bit calm_in;
  bit calm_out;

  pcm_frame_ring_hbridge_drive u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  pfr_drive_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors    (errors),
    .pending   (pending),
    .played    (played),
    .underruns (underruns),
    .overflows (overflows)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] pcm_byte();
    if ($urandom_range(0, 7) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'h7f;
      2: return 8'h80;
      default: return 8'hff;
    endcase
  endfunction

  // sink side stalls
  always @(negedge clk) begin
    int n;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      n = pick_gap();
      if (calm_out || n == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left   <= n - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input logic [1:0] mode, input logic [7:0] data);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.data_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (mode == MODE_UNUSED) ignored++;
    if (mode == MODE_RESTART) restarts++;
    @(negedge clk);
    gap = calm_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int start;
    int r;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_TICK;
    in_ch.data_byte = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty ring, unused mode, restart, extreme bytes, restart mid-frame
    send_req(MODE_TICK, 8'hff);
    send_req(MODE_TICK, 8'h00);
    send_req(MODE_UNUSED, 8'hff);
    send_req(MODE_UNUSED, 8'h00);
    send_req(MODE_RESTART, 8'h55);
    send_req(MODE_DATA, 8'h00);
    send_req(MODE_DATA, 8'h7f);
    send_req(MODE_DATA, 8'h80);
    send_req(MODE_DATA, 8'hff);
    send_req(MODE_DATA, 8'h01);
    send_req(MODE_DATA, 8'hfe);
    send_req(MODE_DATA, 8'h7e);
    send_req(MODE_DATA, 8'h81);
    send_req(MODE_UNUSED, 8'haa);
    send_req(MODE_TICK, 8'h5a);
    send_req(MODE_RESTART, 8'hff);
    send_req(MODE_TICK, 8'h00);
    wait_drained();

    start = sent - ignored;
    while (sent - ignored - start < RANDOM_ITEMS) begin
      r        = $urandom_range(0, 99);
      calm_in  = ($urandom_range(0, 7) == 0);
      calm_out = ($urandom_range(0, 7) == 0);
      if (r < 35) begin
        repeat (FRAME_BYTES) begin
          if ($urandom_range(0, 9) == 0) send_req(MODE_TICK, 8'($urandom_range(0, 255)));
          send_req(MODE_DATA, pcm_byte());
        end
      end else if (r < 80) begin
        repeat ($urandom_range(1, 2 * PAIRS + 8))
          send_req(MODE_TICK, 8'($urandom_range(0, 255)));
      end else if (r < 84) begin
        // fill the whole ring with no ticks so a frame gets dropped
        repeat (FRAMES * FRAME_BYTES) send_req(MODE_DATA, pcm_byte());
      end else if (r < 89) begin
        repeat ($urandom_range(1, FRAME_BYTES - 1)) send_req(MODE_DATA, pcm_byte());
        send_req(MODE_RESTART, 8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        send_req(MODE_RESTART, 8'($urandom_range(0, 255)));
      end else if (r < 97) begin
        send_req(MODE_UNUSED, 8'($urandom_range(0, 255)));
      end else begin
        wait_drained();
      end
    end

    calm_in = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests: %0d ticks played, %0d underruns, %0d overflows",
             sent, played, underruns, overflows);
    $display("with %0d restarts and %0d unused-mode requests", restarts, ignored);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/pfr_pkg.sv
src/pfr_in_if.sv
src/pfr_out_if.sv
src/pfr_ram.sv
src/pfr_front.sv
src/pfr_fifo.sv
src/pfr_back.sv
src/pcm_frame_ring_hbridge_drive.sv
tb/sv/pfr_drive_checker.sv
tb/sv/pcm_frame_ring_hbridge_drive_tb.sv
